// ===== src/tcc_pkg.sv =====
// Shared types, constants and CORDIC tables of the tilt-compensated compass.
package tcc_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int CSTEPS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

   // Datapath widths
   localparam int ZW = 21;   // Q16 angle
   localparam int RW = 20;   // roll vectoring x/y
   localparam int SW = 19;   // sin/cos rotation x/y
   localparam int PW = 38;   // pitch vectoring x/y
   localparam int YW = 58;   // yaw vectoring x/y (Q32)
   localparam int TW = 36;   // sums of products (Q16)
   localparam int MW = 35;   // 16 x 19 products

   localparam logic signed [ZW-1:0] PI_Q16      = 21'sd205887;
   localparam logic signed [ZW-1:0] HALF_PI_Q16 = 21'sd102944;
   localparam logic signed [SW-1:0] CORDIC_X0   = 19'sd39797;

   // Degrees: yaw * 18000000 / 314159 = 57 * yaw + yaw * 92937 / 314159
   localparam logic [5:0]  DEG_INT_MUL  = 6'd57;
   localparam logic [16:0] DEG_FRAC_MUL = 17'd92937;
   localparam logic [18:0] DEG_DIV      = 19'd314159;
   localparam logic [19:0] DEG_RECIP    = 20'd874964;   // floor(2^38 / 314159)
   localparam logic [27:0] DEG360_Q16   = 28'd23592960;

   typedef enum logic [2:0] {
      KIND_RIGHT = 3'd0,
      KIND_LEFT  = 3'd1,
      KIND_UP    = 3'd2,
      KIND_DOWN  = 3'd3,
      KIND_ANGLE = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      CSR_SIDE_LIMIT     = 2'd0,
      CSR_FORE_LIMIT     = 2'd1,
      CSR_HEADING_OFFSET = 2'd2
   } csr_index_type;

   // Sample and intermediate values that travel with every item
   typedef struct packed {
      logic signed [15:0]   ax;
      logic signed [15:0]   ay;
      logic signed [15:0]   az;
      logic signed [15:0]   mx;
      logic signed [15:0]   my;
      logic signed [15:0]   mz;
      kind_type             kind;
      logic signed [SW-1:0] cr;
      logic signed [SW-1:0] sr;
      logic signed [TW-1:0] t;
      logic signed [TW-1:0] u;
   } side_type;

   typedef struct packed {
      logic                 zero;
      logic signed [RW-1:0] x;
      logic signed [RW-1:0] y;
      logic signed [ZW-1:0] z;
   } vroll_type;

   typedef struct packed {
      logic                 neg;
      logic signed [SW-1:0] x;
      logic signed [SW-1:0] y;
      logic signed [ZW-1:0] z;
   } rot_type;

   typedef struct packed {
      logic                 zero;
      logic signed [PW-1:0] x;
      logic signed [PW-1:0] y;
      logic signed [ZW-1:0] z;
   } vpitch_type;

   typedef struct packed {
      logic                 zero;
      logic signed [YW-1:0] x;
      logic signed [YW-1:0] y;
      logic signed [ZW-1:0] z;
   } vyaw_type;

   // atan(2^-i) in Q16
   function automatic logic signed [ZW-1:0] atan_q16(input int i);
      logic signed [ZW-1:0] v;
      case (i)
         0:  v = 21'sd51472;
         1:  v = 21'sd30385;
         2:  v = 21'sd16055;
         3:  v = 21'sd8150;
         4:  v = 21'sd4091;
         5:  v = 21'sd2047;
         6:  v = 21'sd1024;
         7:  v = 21'sd512;
         8:  v = 21'sd256;
         9:  v = 21'sd128;
         10: v = 21'sd64;
         11: v = 21'sd32;
         12: v = 21'sd16;
         13: v = 21'sd8;
         14: v = 21'sd4;
         15: v = 21'sd2;
         16: v = 21'sd1;
         default: v = 21'sd0;
      endcase
      return v;
   endfunction

endpackage

// ===== src/tilt_compensated_compass_unit.sv =====
// Top level: fully pipelined tilt-compensated compass heading and tilt classifier.
//
// One accelerometer and one magnetometer sample go in per item; one result
// (report kind and heading in whole degrees, 0..360) comes out. The datapath
// is a single pipeline of 5*CSTEPS+19 register stages (99 with 16 CORDIC
// steps): roll atan2, roll sin/cos, pitch atan2, pitch sin/cos and yaw atan2
// each take one stage per CORDIC iteration plus a setup stage, followed by
// the product, degree conversion and heading fold stages. One item can be
// accepted every cycle while the output is not stalled. The whole pipeline
// holds while a result waits on rsp_ready, so req_ready falls in the same
// cycle. The user must write tilt limits and heading offset through the csr
// port only while no item is in flight; the block does not enforce this. The
// csr port always accepts, and an index of 3 is ignored.
module tilt_compensated_compass_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_mag_x,
   input  logic signed [15:0] req_mag_y,
   input  logic signed [15:0] req_mag_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_report_kind,
   output logic [8:0]         rsp_heading_deg,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [14:0]        csr_data
);

   localparam int CS  = tcc_pkg::CSTEPS;
   localparam int SB  = CS + 1;        // roll sin/cos setup
   localparam int SC0 = 2*CS + 2;      // cr, sr
   localparam int SC1 = 2*CS + 3;      // roll products
   localparam int SC2 = 2*CS + 4;      // d, t, u
   localparam int SD  = 2*CS + 5;      // pitch atan2 setup
   localparam int SE  = 3*CS + 6;      // pitch sin/cos setup
   localparam int SF0 = 4*CS + 7;      // cp, sp
   localparam int SF1 = 4*CS + 8;      // pitch products
   localparam int SF2 = 4*CS + 9;      // yaw vector
   localparam int SG  = 4*CS + 10;     // yaw atan2 setup
   localparam int SH0 = 5*CS + 11;     // |yaw|
   localparam int NST = 5*CS + 19;     // last stage is the output register

   localparam int ZW = tcc_pkg::ZW;
   localparam int RW = tcc_pkg::RW;
   localparam int SW = tcc_pkg::SW;
   localparam int PW = tcc_pkg::PW;
   localparam int YW = tcc_pkg::YW;
   localparam int TW = tcc_pkg::TW;
   localparam int MW = tcc_pkg::MW;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [14:0] side_limit_ff;
   logic [14:0] fore_limit_ff;
   logic [8:0]  offset_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_limit_ff <= 15'd600;
         fore_limit_ff <= 15'd800;
         offset_ff     <= 9'd88;
      end else if (csr_valid) begin
         case (csr_index)
            tcc_pkg::CSR_SIDE_LIMIT:     side_limit_ff <= csr_data;
            tcc_pkg::CSR_FORE_LIMIT:     fore_limit_ff <= csr_data;
            tcc_pkg::CSR_HEADING_OFFSET: offset_ff     <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Pipeline control: every stage advances together
   // ---------------------------------------------------------------
   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_in;
   logic           adv;

   assign adv       = !vld_ff[NST-1] || rsp_ready;
   assign req_ready = adv;
   assign vld_in    = {vld_ff[NST-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage registers
   // ---------------------------------------------------------------
   tcc_pkg::side_type   side_ff [0:NST-1];
   tcc_pkg::side_type   side_in [0:NST-1];
   tcc_pkg::vroll_type  roll_ff [0:CS];
   tcc_pkg::vroll_type  roll_in [0:CS];
   tcc_pkg::rot_type    rot1_ff [0:CS];
   tcc_pkg::rot_type    rot1_in [0:CS];
   tcc_pkg::vpitch_type pitch_ff [0:CS];
   tcc_pkg::vpitch_type pitch_in [0:CS];
   tcc_pkg::rot_type    rot2_ff [0:CS];
   tcc_pkg::rot_type    rot2_in [0:CS];
   tcc_pkg::vyaw_type   yaw_ff [0:CS];
   tcc_pkg::vyaw_type   yaw_in [0:CS];

   logic signed [MW-1:0] axsr_ff, azcr_ff, mxsr_ff, mzcr_ff, mxcr_ff, mzsr_ff;
   logic signed [MW-1:0] axsr_in, azcr_in, mxsr_in, mzcr_in, mxcr_in, mzsr_in;
   logic signed [TW-1:0] dsum_ff, dsum_in;
   logic signed [SW-1:0] cp_ff, sp_ff, cp_in, sp_in;
   logic signed [54:0]   tsp_ff, tsp_in;
   logic signed [MW-1:0] mycp_ff, mycp_in;
   logic signed [55:0]   yv_ff, yv_in, xv_ff, xv_in;
   logic [19:0]          ya_ff, ya_in;           // |yaw|
   logic                 yneg_ff [0:4];
   logic                 yneg_in [0:4];
   logic [25:0]          p1_ff [0:2];            // 57 * |yaw|
   logic [25:0]          p1_in [0:2];
   logic [36:0]          n_ff [0:1];             // 92937 * |yaw|
   logic [36:0]          n_in [0:1];
   logic [18:0]          qe_ff [0:1];            // quotient estimate
   logic [18:0]          qe_in [0:1];
   logic [19:0]          rem_ff, rem_in;
   logic [26:0]          qdeg_ff, qdeg_in;       // |deg| in Q16
   logic [27:0]          hd5_ff, hd5_in, hd6_ff, hd6_in;
   logic [8:0]           heading_ff, heading_in;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NST; k++) side_ff[k] <= side_in[k];
         for (int k = 0; k <= CS; k++) begin
            roll_ff[k]  <= roll_in[k];
            rot1_ff[k]  <= rot1_in[k];
            pitch_ff[k] <= pitch_in[k];
            rot2_ff[k]  <= rot2_in[k];
            yaw_ff[k]   <= yaw_in[k];
         end
         axsr_ff <= axsr_in;  azcr_ff <= azcr_in;  mxsr_ff <= mxsr_in;
         mzcr_ff <= mzcr_in;  mxcr_ff <= mxcr_in;  mzsr_ff <= mzsr_in;
         dsum_ff <= dsum_in;
         cp_ff   <= cp_in;    sp_ff   <= sp_in;
         tsp_ff  <= tsp_in;   mycp_ff <= mycp_in;
         yv_ff   <= yv_in;    xv_ff   <= xv_in;
         ya_ff   <= ya_in;
         for (int k = 0; k < 5; k++) yneg_ff[k] <= yneg_in[k];
         for (int k = 0; k < 3; k++) p1_ff[k] <= p1_in[k];
         for (int k = 0; k < 2; k++) begin
            n_ff[k]  <= n_in[k];
            qe_ff[k] <= qe_in[k];
         end
         rem_ff     <= rem_in;
         qdeg_ff    <= qdeg_in;
         hd5_ff     <= hd5_in;
         hd6_ff     <= hd6_in;
         heading_ff <= heading_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 0: capture sample, classify tilt, roll atan2 setup
   // ---------------------------------------------------------------
   logic signed [16:0] ay_w, ax_w, side_w, fore_w;
   tcc_pkg::kind_type  kind_w;

   assign ay_w   = 17'(req_accel_y);
   assign ax_w   = 17'(req_accel_x);
   assign side_w = $signed({2'b00, side_limit_ff});
   assign fore_w = $signed({2'b00, fore_limit_ff});

   always_comb begin
      if (ay_w < -side_w)      kind_w = tcc_pkg::KIND_RIGHT;
      else if (ay_w > side_w)  kind_w = tcc_pkg::KIND_LEFT;
      else if (ax_w < -fore_w) kind_w = tcc_pkg::KIND_UP;
      else if (ax_w > fore_w)  kind_w = tcc_pkg::KIND_DOWN;
      else                     kind_w = tcc_pkg::KIND_ANGLE;
   end

   always_comb begin
      side_in[0]      = '0;
      side_in[0].ax   = req_accel_x;
      side_in[0].ay   = req_accel_y;
      side_in[0].az   = req_accel_z;
      side_in[0].mx   = req_mag_x;
      side_in[0].my   = req_mag_y;
      side_in[0].mz   = req_mag_z;
      side_in[0].kind = kind_w;

      // roll = atan2(ax, az); turn through pi when az is negative
      roll_in[0].zero = (req_accel_x == 16'sd0) && (req_accel_z == 16'sd0);
      if (req_accel_z < 16'sd0) begin
         roll_in[0].x = -RW'(req_accel_z);
         roll_in[0].y = -RW'(req_accel_x);
         roll_in[0].z = (req_accel_x >= 16'sd0) ? tcc_pkg::PI_Q16 : -tcc_pkg::PI_Q16;
      end else begin
         roll_in[0].x = RW'(req_accel_z);
         roll_in[0].y = RW'(req_accel_x);
         roll_in[0].z = '0;
      end
   end

   // Side data ride along; cr/sr and t/u are filled in on the way
   for (genvar k = 1; k < NST; k++) begin : g_side
      always_comb begin
         side_in[k] = side_ff[k-1];
         if (k == SC0) begin
            side_in[k].cr = rot1_ff[CS].neg ? -rot1_ff[CS].x : rot1_ff[CS].x;
            side_in[k].sr = rot1_ff[CS].neg ? -rot1_ff[CS].y : rot1_ff[CS].y;
         end
         if (k == SC2) begin
            side_in[k].t = TW'(mxsr_ff) + TW'(mzcr_ff);
            side_in[k].u = TW'(mxcr_ff) - TW'(mzsr_ff);
         end
      end
   end

   // ---------------------------------------------------------------
   // CORDIC iterations, one per stage
   // ---------------------------------------------------------------
   for (genvar i = 1; i <= CS; i++) begin : g_iter
      localparam logic signed [ZW-1:0] AT = tcc_pkg::atan_q16(i-1);

      // roll vectoring
      always_comb begin
         roll_in[i] = roll_ff[i-1];
         if (roll_ff[i-1].y > 0) begin
            roll_in[i].x = roll_ff[i-1].x + (roll_ff[i-1].y >>> (i-1));
            roll_in[i].y = roll_ff[i-1].y - (roll_ff[i-1].x >>> (i-1));
            roll_in[i].z = roll_ff[i-1].z + AT;
         end else begin
            roll_in[i].x = roll_ff[i-1].x - (roll_ff[i-1].y >>> (i-1));
            roll_in[i].y = roll_ff[i-1].y + (roll_ff[i-1].x >>> (i-1));
            roll_in[i].z = roll_ff[i-1].z - AT;
         end
      end

      // roll rotation
      always_comb begin
         rot1_in[i] = rot1_ff[i-1];
         if (rot1_ff[i-1].z >= 0) begin
            rot1_in[i].x = rot1_ff[i-1].x - (rot1_ff[i-1].y >>> (i-1));
            rot1_in[i].y = rot1_ff[i-1].y + (rot1_ff[i-1].x >>> (i-1));
            rot1_in[i].z = rot1_ff[i-1].z - AT;
         end else begin
            rot1_in[i].x = rot1_ff[i-1].x + (rot1_ff[i-1].y >>> (i-1));
            rot1_in[i].y = rot1_ff[i-1].y - (rot1_ff[i-1].x >>> (i-1));
            rot1_in[i].z = rot1_ff[i-1].z + AT;
         end
      end

      // pitch vectoring
      always_comb begin
         pitch_in[i] = pitch_ff[i-1];
         if (pitch_ff[i-1].y > 0) begin
            pitch_in[i].x = pitch_ff[i-1].x + (pitch_ff[i-1].y >>> (i-1));
            pitch_in[i].y = pitch_ff[i-1].y - (pitch_ff[i-1].x >>> (i-1));
            pitch_in[i].z = pitch_ff[i-1].z + AT;
         end else begin
            pitch_in[i].x = pitch_ff[i-1].x - (pitch_ff[i-1].y >>> (i-1));
            pitch_in[i].y = pitch_ff[i-1].y + (pitch_ff[i-1].x >>> (i-1));
            pitch_in[i].z = pitch_ff[i-1].z - AT;
         end
      end

      // pitch rotation
      always_comb begin
         rot2_in[i] = rot2_ff[i-1];
         if (rot2_ff[i-1].z >= 0) begin
            rot2_in[i].x = rot2_ff[i-1].x - (rot2_ff[i-1].y >>> (i-1));
            rot2_in[i].y = rot2_ff[i-1].y + (rot2_ff[i-1].x >>> (i-1));
            rot2_in[i].z = rot2_ff[i-1].z - AT;
         end else begin
            rot2_in[i].x = rot2_ff[i-1].x + (rot2_ff[i-1].y >>> (i-1));
            rot2_in[i].y = rot2_ff[i-1].y - (rot2_ff[i-1].x >>> (i-1));
            rot2_in[i].z = rot2_ff[i-1].z + AT;
         end
      end

      // yaw vectoring
      always_comb begin
         yaw_in[i] = yaw_ff[i-1];
         if (yaw_ff[i-1].y > 0) begin
            yaw_in[i].x = yaw_ff[i-1].x + (yaw_ff[i-1].y >>> (i-1));
            yaw_in[i].y = yaw_ff[i-1].y - (yaw_ff[i-1].x >>> (i-1));
            yaw_in[i].z = yaw_ff[i-1].z + AT;
         end else begin
            yaw_in[i].x = yaw_ff[i-1].x - (yaw_ff[i-1].y >>> (i-1));
            yaw_in[i].y = yaw_ff[i-1].y + (yaw_ff[i-1].x >>> (i-1));
            yaw_in[i].z = yaw_ff[i-1].z - AT;
         end
      end
   end

   // ---------------------------------------------------------------
   // Roll sin/cos setup: fold angle into [-pi/2, pi/2]
   // ---------------------------------------------------------------
   logic signed [ZW-1:0] roll_w;
   assign roll_w = roll_ff[CS].zero ? '0 : roll_ff[CS].z;

   always_comb begin
      rot1_in[0].x   = tcc_pkg::CORDIC_X0;
      rot1_in[0].y   = '0;
      rot1_in[0].neg = 1'b0;
      rot1_in[0].z   = roll_w;
      if (roll_w > tcc_pkg::HALF_PI_Q16) begin
         rot1_in[0].z   = roll_w - tcc_pkg::PI_Q16;
         rot1_in[0].neg = 1'b1;
      end else if (roll_w < -tcc_pkg::HALF_PI_Q16) begin
         rot1_in[0].z   = roll_w + tcc_pkg::PI_Q16;
         rot1_in[0].neg = 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Roll products, then d = ax*sr + az*cr
   // ---------------------------------------------------------------
   assign axsr_in = MW'(side_ff[SC0].ax) * MW'(side_ff[SC0].sr);
   assign azcr_in = MW'(side_ff[SC0].az) * MW'(side_ff[SC0].cr);
   assign mxsr_in = MW'(side_ff[SC0].mx) * MW'(side_ff[SC0].sr);
   assign mzcr_in = MW'(side_ff[SC0].mz) * MW'(side_ff[SC0].cr);
   assign mxcr_in = MW'(side_ff[SC0].mx) * MW'(side_ff[SC0].cr);
   assign mzsr_in = MW'(side_ff[SC0].mz) * MW'(side_ff[SC0].sr);
   assign dsum_in = TW'(axsr_ff) + TW'(azcr_ff);

   // ---------------------------------------------------------------
   // Pitch atan2 setup: (ay * 2^16 * sgn d, |d|); x never negative
   // ---------------------------------------------------------------
   logic signed [PW-1:0] num_w;
   assign num_w = PW'(side_ff[SC2].ay) <<< 16;

   always_comb begin
      pitch_in[0].zero = (dsum_ff == '0) && (side_ff[SC2].ay == 16'sd0);
      pitch_in[0].z    = '0;
      if (dsum_ff < 0) begin
         pitch_in[0].x = -PW'(dsum_ff);
         pitch_in[0].y = -num_w;
      end else begin
         pitch_in[0].x = PW'(dsum_ff);
         pitch_in[0].y = num_w;
      end
   end

   // ---------------------------------------------------------------
   // Pitch sin/cos setup: pitch = -atan2
   // ---------------------------------------------------------------
   logic signed [ZW-1:0] pitch_w;
   assign pitch_w = pitch_ff[CS].zero ? '0 : -pitch_ff[CS].z;

   always_comb begin
      rot2_in[0].x   = tcc_pkg::CORDIC_X0;
      rot2_in[0].y   = '0;
      rot2_in[0].neg = 1'b0;
      rot2_in[0].z   = pitch_w;
      if (pitch_w > tcc_pkg::HALF_PI_Q16) begin
         rot2_in[0].z   = pitch_w - tcc_pkg::PI_Q16;
         rot2_in[0].neg = 1'b1;
      end else if (pitch_w < -tcc_pkg::HALF_PI_Q16) begin
         rot2_in[0].z   = pitch_w + tcc_pkg::PI_Q16;
         rot2_in[0].neg = 1'b1;
      end
   end

   assign cp_in = rot2_ff[CS].neg ? -rot2_ff[CS].x : rot2_ff[CS].x;
   assign sp_in = rot2_ff[CS].neg ? -rot2_ff[CS].y : rot2_ff[CS].y;

   // ---------------------------------------------------------------
   // Yaw vector in Q32
   // ---------------------------------------------------------------
   assign tsp_in  = 55'(side_ff[SF0].t) * 55'(sp_ff);
   assign mycp_in = MW'(side_ff[SF0].my) * MW'(cp_ff);
   assign yv_in   = 56'(tsp_ff) + (56'(mycp_ff) <<< 16);
   assign xv_in   = 56'(side_ff[SF1].u) <<< 16;

   always_comb begin
      yaw_in[0].zero = (yv_ff == '0) && (xv_ff == '0);
      if (xv_ff < 0) begin
         yaw_in[0].x = -YW'(xv_ff);
         yaw_in[0].y = -YW'(yv_ff);
         yaw_in[0].z = (yv_ff >= 0) ? tcc_pkg::PI_Q16 : -tcc_pkg::PI_Q16;
      end else begin
         yaw_in[0].x = YW'(xv_ff);
         yaw_in[0].y = YW'(yv_ff);
         yaw_in[0].z = '0;
      end
   end

   // ---------------------------------------------------------------
   // Radians to Q16 degrees, truncated toward zero, on the magnitude
   // ---------------------------------------------------------------
   logic signed [ZW-1:0] yaw_w;
   logic [43:0]          qprod_w;
   logic [37:0]          rem_w;

   assign yaw_w      = yaw_ff[CS].zero ? '0 : yaw_ff[CS].z;
   assign yneg_in[0] = (yaw_w < 0);
   assign ya_in      = (yaw_w < 0) ? 20'(-yaw_w) : 20'(yaw_w);

   assign yneg_in[1] = yneg_ff[0];
   assign p1_in[0]   = 26'(tcc_pkg::DEG_INT_MUL) * 26'(ya_ff);
   assign n_in[0]    = 37'(tcc_pkg::DEG_FRAC_MUL) * 37'(ya_ff);

   // quotient estimate, low by at most one
   assign qprod_w    = 44'(n_ff[0][36:13]) * 44'(tcc_pkg::DEG_RECIP);
   assign yneg_in[2] = yneg_ff[1];
   assign p1_in[1]   = p1_ff[0];
   assign n_in[1]    = n_ff[0];
   assign qe_in[0]   = qprod_w[43:25];

   assign rem_w      = 38'(n_ff[1]) - 38'(qe_ff[0]) * 38'(tcc_pkg::DEG_DIV);
   assign yneg_in[3] = yneg_ff[2];
   assign p1_in[2]   = p1_ff[1];
   assign qe_in[1]   = qe_ff[0];
   assign rem_in     = rem_w[19:0];

   assign yneg_in[4] = yneg_ff[3];
   assign qdeg_in    = 27'(p1_ff[2]) + 27'(qe_ff[1])
                     + 27'(rem_ff >= 20'(tcc_pkg::DEG_DIV));

   // ---------------------------------------------------------------
   // Heading fold: flip positive angles, negate, add offset, wrap twice
   // ---------------------------------------------------------------
   logic [27:0] base_w;
   assign base_w = (!yneg_ff[4] && (qdeg_ff != '0))
                 ? tcc_pkg::DEG360_Q16 - 28'(qdeg_ff) : 28'(qdeg_ff);
   assign hd5_in = base_w + 28'({offset_ff, 16'h0000});
   assign hd6_in = (hd5_ff > tcc_pkg::DEG360_Q16) ? hd5_ff - tcc_pkg::DEG360_Q16 : hd5_ff;

   logic [27:0] hd7_w;
   assign hd7_w      = (hd6_ff > tcc_pkg::DEG360_Q16) ? hd6_ff - tcc_pkg::DEG360_Q16 : hd6_ff;
   assign heading_in = hd7_w[24:16];

   // ---------------------------------------------------------------
   // Result
   // ---------------------------------------------------------------
   assign rsp_valid       = vld_ff[NST-1];
   assign rsp_report_kind = side_ff[NST-1].kind;
   assign rsp_heading_deg = heading_ff;

`ifndef SYNTHESIS
   // no item enters while a result is held
   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NST-1] && !rsp_ready) |-> !req_ready)
      else $error("item accepted while output stalled");

   // a stalled pipeline keeps its occupancy
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline occupancy changed during stall");

   // an accepted item reaches the next stage
   a_accept_moves: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[0])
      else $error("accepted item lost at entry");

   // the fold always lands in 0..360
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_heading_deg <= 9'd360))
      else $error("heading out of range");
`endif

endmodule
